// ===== sv/erg_pkg.sv =====
package erg_pkg;

	// Largest supported step count and the widths that follow from it.
	localparam int MAX_STEPS = 16;
	localparam int PW        = 16;
	localparam int FW        = 4;
	localparam int CW        = $clog2(MAX_STEPS + 1);

	// Commands from the controller to the datapath; at most one is high per cycle.
	typedef struct packed {
		logic load;
		logic qstep;
		logic fstep;
		logic app_a;
		logic advance;
		logic mask;
		logic rot_load;
		logic rot_step;
		logic capture;
	} erg_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic d_ge_r;
		logic d_zero;
		logic r_zero;
		logic chain_more;
		logic pat_zero;
		logic pat_lsb;
		logic ctr_zero;
	} erg_sts_t;

endpackage

// ===== sv/erg_dp.sv =====
module erg_dp import erg_pkg::*; (
	input  logic           clk,
	input  erg_cmd_t       cmd,
	output erg_sts_t       sts,
	input  logic [FW-1:0]  steps_minus_one,
	input  logic [FW-1:0]  pulses_minus_one,
	input  logic [FW-1:0]  rotation,
	output logic [PW-1:0]  step_pattern
);

	// Remainder chain: divisor, current remainder and level.
	logic [CW-1:0] len_q, div_q, rem_q, lvl_q, ctr_q;
	logic [FW-1:0] rot_q;
	// Strings of the two previous levels (A older, B newer) and the one being built.
	logic [PW-1:0] a_pat_q, b_pat_q, c_pat_q, pat_q, out_q;
	logic [CW-1:0] a_len_q, b_len_q, c_len_q;

	logic [CW-1:0] len_in, dens_in;
	logic [PW-1:0] src_pat, app_pat, len_mask, pat_rot1;
	logic [CW-1:0] src_len, app_len;
	logic [CW:0]   len_sum;

	// Step and pulse counts, each clamped.
	always_comb begin
		len_in = CW'(steps_minus_one) + CW'(1);
		if (len_in > CW'(MAX_STEPS)) begin
			len_in = CW'(MAX_STEPS);
		end
		dens_in = CW'(pulses_minus_one) + CW'(1);
		if (dens_in > len_in) begin
			dens_in = len_in;
		end
	end

	// Append A or B to the string under construction; the length saturates at the width.
	always_comb begin
		src_pat = cmd.app_a ? a_pat_q : b_pat_q;
		src_len = cmd.app_a ? a_len_q : b_len_q;
		app_pat = c_pat_q | (src_pat << c_len_q);
		len_sum = {1'b0, c_len_q} + {1'b0, src_len};
		app_len = (len_sum > (CW + 1)'(PW)) ? CW'(PW) : len_sum[CW-1:0];
	end

	// Rotation up by one step within the step count.
	assign len_mask = ~({PW{1'b1}} << len_q);
	assign pat_rot1 = ((pat_q << 1) | (pat_q >> CW'(len_q - CW'(1)))) & len_mask;

	// Status for the controller.
	assign sts.d_ge_r     = (div_q >= rem_q);
	assign sts.d_zero     = (div_q == '0);
	assign sts.r_zero     = (rem_q == '0);
	assign sts.chain_more = (rem_q > CW'(1)) && (lvl_q < CW'(MAX_STEPS));
	assign sts.pat_zero   = (pat_q == '0);
	assign sts.pat_lsb    = pat_q[0];
	assign sts.ctr_zero   = (ctr_q == '0);

	// Datapath registers, updated by whichever single command is high.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q   <= len_in;
			rot_q   <= rotation;
			div_q   <= len_in - dens_in;
			rem_q   <= dens_in;
			lvl_q   <= '0;
			a_pat_q <= PW'(1);
			a_len_q <= CW'(1);
			b_pat_q <= '0;
			b_len_q <= CW'(1);
			c_pat_q <= '0;
			c_len_q <= '0;
		end else if (cmd.qstep) begin
			div_q   <= div_q - rem_q;
			c_pat_q <= app_pat;
			c_len_q <= app_len;
		end else if (cmd.fstep) begin
			div_q   <= div_q - CW'(1);
			c_pat_q <= app_pat;
			c_len_q <= app_len;
		end else if (cmd.app_a) begin
			c_pat_q <= app_pat;
			c_len_q <= app_len;
		end else if (cmd.advance) begin
			a_pat_q <= b_pat_q;
			a_len_q <= b_len_q;
			b_pat_q <= c_pat_q;
			b_len_q <= c_len_q;
			c_pat_q <= '0;
			c_len_q <= '0;
			div_q   <= rem_q;
			rem_q   <= div_q;
			lvl_q   <= lvl_q + CW'(1);
		end else if (cmd.mask) begin
			pat_q <= c_pat_q & len_mask;
			ctr_q <= len_q;
		end else if (cmd.rot_load) begin
			ctr_q <= CW'(rot_q);
		end else if (cmd.rot_step) begin
			pat_q <= pat_rot1;
			ctr_q <= ctr_q - CW'(1);
		end else if (cmd.capture) begin
			out_q <= pat_q;
		end
	end

	assign step_pattern = out_q;

endmodule

// ===== sv/erg_ctrl.sv =====
module erg_ctrl import erg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	output logic     result_valid,
	input  logic     result_ready,
	input  erg_sts_t sts,
	output erg_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_QUOT,
		S_ADV,
		S_CHK,
		S_FIN,
		S_MASK,
		S_NORM,
		S_ROT,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   out_free;

	// The output register can take a new word when empty or being emptied.
	assign out_free = !result_valid_q || result_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_QUOT;
				end
			end
			S_QUOT: begin
				if (sts.d_ge_r) begin
					cmd.qstep = 1'b1;
				end else begin
					cmd.app_a = 1'b1;
					state_d   = S_ADV;
				end
			end
			S_ADV: begin
				cmd.advance = 1'b1;
				state_d     = S_CHK;
			end
			S_CHK: begin
				state_d = sts.chain_more ? S_QUOT : S_FIN;
			end
			S_FIN: begin
				if (!sts.d_zero) begin
					cmd.fstep = 1'b1;
				end else begin
					cmd.app_a = !sts.r_zero;
					state_d   = S_MASK;
				end
			end
			S_MASK: begin
				cmd.mask = 1'b1;
				state_d  = S_NORM;
			end
			S_NORM: begin
				if (!sts.ctr_zero && !sts.pat_lsb && !sts.pat_zero) begin
					cmd.rot_step = 1'b1;
				end else begin
					cmd.rot_load = 1'b1;
					state_d      = S_ROT;
				end
			end
			S_ROT: begin
				if (!sts.ctr_zero) begin
					cmd.rot_step = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

endmodule

// ===== sv/euclidean_rhythm_generator_unit.sv =====
// Sequence per word: load, then per chain level the quotient steps, the append of A and the
// advance; then the final repeat steps, the mask, the normalizing shifts (fewer than the step
// count), the rotation load and the rotation shifts, and last the capture into the result word.
// A new word is taken only in the idle state after the capture, so no word is taken before the
// last one is through; a new word is taken while a finished result word waits.
// Reset clears the controller and valid flag.
module euclidean_rhythm_generator_unit import erg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  logic [FW-1:0] steps_minus_one,
	input  logic [FW-1:0] pulses_minus_one,
	input  logic [FW-1:0] rotation,
	output logic          result_valid,
	input  logic          result_ready,
	output logic [PW-1:0] step_pattern
);

	erg_cmd_t cmd;
	erg_sts_t sts;

	// Sequencer for the remainder chain, normalization and rotation.
	erg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Chain arithmetic, pattern strings and output register.
	erg_dp u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.sts              (sts),
		.steps_minus_one  (steps_minus_one),
		.pulses_minus_one (pulses_minus_one),
		.rotation         (rotation),
		.step_pattern     (step_pattern)
	);

endmodule

// ===== sv/erg_checker.sv =====
module erg_checker import erg_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_ready,
	input logic [FW-1:0] steps_minus_one,
	input logic [FW-1:0] pulses_minus_one,
	input logic [FW-1:0] rotation,
	input logic          result_valid,
	input logic          result_ready,
	input logic [PW-1:0] step_pattern
);

	// A word in flight blocks the input until its result is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken while a word is in flight");

	// A new result word appears only as the sequencer returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("result word raised while busy");

	// Every pattern has at least one onset.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> step_pattern != '0)
		else $error("empty pattern delivered");

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(step_pattern))
		else $error("stalled result word changed");

endmodule

bind euclidean_rhythm_generator_unit erg_checker u_erg_checker (.*);

// ===== bench/euclidean_rhythm_generator_unit_tb.sv =====
module euclidean_rhythm_generator_unit_tb;
	import erg_pkg::*;

	localparam int RESET_CYCLES   = 10;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RANDOM_WORDS   = 630;
	localparam int DRAIN_CYCLES   = 200;
	localparam int LONG_HOLD      = 500;
	localparam int HOLD_AFTER     = 150;
	localparam int DIRECTED_COUNT = 21;

	logic          clk;
	logic          arst_n;
	logic          item_valid;
	logic          item_ready;
	logic [FW-1:0] steps_minus_one;
	logic [FW-1:0] pulses_minus_one;
	logic [FW-1:0] rotation;
	logic          result_valid;
	logic          result_ready;
	logic [PW-1:0] step_pattern;

	// One directed request; the pattern is used only where typed is set.
	typedef struct packed {
		logic [FW-1:0] steps_m1;
		logic [FW-1:0] pulses_m1;
		logic [FW-1:0] rot;
		logic          typed;
		logic [PW-1:0] pattern;
	} rhythm_case_t;

	rhythm_case_t directed_cases [DIRECTED_COUNT] = '{
		'{4'd0,  4'd0,  4'd0,  1'b1, 16'h0001},
		'{4'd0,  4'd15, 4'd15, 1'b1, 16'h0001},
		'{4'd15, 4'd15, 4'd0,  1'b1, 16'hFFFF},
		'{4'd15, 4'd15, 4'd15, 1'b1, 16'hFFFF},
		'{4'd7,  4'd15, 4'd3,  1'b1, 16'h00FF},
		'{4'd15, 4'd0,  4'd0,  1'b1, 16'h0001},
		'{4'd15, 4'd0,  4'd5,  1'b1, 16'h0020},
		'{4'd15, 4'd0,  4'd15, 1'b1, 16'h8000},
		'{4'd3,  4'd0,  4'd15, 1'b1, 16'h0008},
		'{4'd1,  4'd0,  4'd1,  1'b1, 16'h0002},
		'{4'd6,  4'd9,  4'd2,  1'b1, 16'h007F},
		'{4'd5,  4'd0,  4'd4,  1'b1, 16'h0010},
		'{4'd7,  4'd2,  4'd0,  1'b0, 16'h0000},
		'{4'd15, 4'd4,  4'd0,  1'b0, 16'h0000},
		'{4'd15, 4'd14, 4'd7,  1'b0, 16'h0000},
		'{4'd12, 4'd4,  4'd13, 1'b0, 16'h0000},
		'{4'd4,  4'd1,  4'd0,  1'b0, 16'h0000},
		'{4'd15, 4'd7,  4'd0,  1'b0, 16'h0000},
		'{4'd9,  4'd2,  4'd9,  1'b0, 16'h0000},
		'{4'd10, 4'd6,  4'd3,  1'b0, 16'h0000},
		'{4'd14, 4'd13, 4'd1,  1'b0, 16'h0000}
	};

	logic [PW-1:0] expected_patterns [$];
	int            words_sent;
	int            patterns_checked;
	int            mismatches;
	int            cycle_count;
	bit            long_hold_done;

	euclidean_rhythm_generator_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.steps_minus_one  (steps_minus_one),
		.pulses_minus_one (pulses_minus_one),
		.rotation         (rotation),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.step_pattern     (step_pattern)
	);

	// Free-running clock with a period of four units.
	initial begin
		clk = 1'b0;
	end
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Rotates the low len bits of a pattern upward by k, modulo len.
	function automatic logic [PW-1:0] rotate_within(logic [PW-1:0] pat, int len, int k);
		logic [31:0] wide;
		logic [31:0] mask;
		mask = (32'd1 << len) - 32'd1;
		wide = {16'd0, pat} & mask;
		k = k % len;
		if (k != 0) begin
			wide = ((wide << k) | (wide >> (len - k))) & mask;
		end
		return wide[PW-1:0];
	endfunction

	// Bjorklund remainder chain, expanded bottom up. Each level keeps only the
	// first sixteen steps of its run, which is all the final pattern can use.
	function automatic logic [PW-1:0] euclid_pattern(logic [FW-1:0] s_m1, logic [FW-1:0] p_m1,
			logic [FW-1:0] rot);
		int            len;
		int            dens;
		int            divisor;
		int            level;
		int            lv;
		int            pos;
		int            src;
		int            k;
		int            j;
		int            quot [MAX_STEPS+2];
		int            rest [MAX_STEPS+2];
		logic [PW-1:0] run_bits [MAX_STEPS+4];
		int            run_len [MAX_STEPS+4];
		logic [PW-1:0] pat;
		len  = int'(s_m1) + 1;
		dens = int'(p_m1) + 1;
		if (len > MAX_STEPS) begin
			len = MAX_STEPS;
		end
		if (dens > len) begin
			dens = len;
		end
		for (k = 0; k < MAX_STEPS + 2; k++) begin
			quot[k] = 0;
			rest[k] = 0;
		end

		// Build the chain of quotients and remainders.
		divisor = len - dens;
		rest[0] = dens;
		level   = 0;
		do begin
			quot[level]     = divisor / rest[level];
			rest[level + 1] = divisor % rest[level];
			divisor         = rest[level];
			level++;
		end while (rest[level] > 1 && level < MAX_STEPS);
		quot[level] = divisor;

		// Slot 0 is the onset run, slot 1 the rest run; chain level lv sits at lv + 2.
		run_bits[0] = 16'h0001;
		run_len[0]  = 1;
		run_bits[1] = 16'h0000;
		run_len[1]  = 1;
		for (lv = 0; lv <= level; lv++) begin
			run_bits[lv + 2] = '0;
			pos = 0;
			for (k = 0; k <= quot[lv] && pos < PW; k++) begin
				if (k < quot[lv]) begin
					src = lv + 1;
				end else if (rest[lv] != 0) begin
					src = lv;
				end else begin
					break;
				end
				for (j = 0; j < run_len[src]; j++) begin
					if (pos + j < PW) begin
						run_bits[lv + 2][pos + j] = run_bits[src][j];
					end
				end
				pos += run_len[src];
			end
			run_len[lv + 2] = (pos > PW) ? PW : pos;
		end

		// Normalize so step 0 holds an onset, then apply the user rotation.
		pat = rotate_within(run_bits[level + 2], len, 0);
		if (pat != '0) begin
			for (k = 0; k < len && !pat[0]; k++) begin
				pat = rotate_within(pat, len, 1);
			end
		end
		return rotate_within(pat, len, int'(rot));
	endfunction

	// Idle length between words or a stall of the receiver: mostly short, a few long.
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 88) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offers one word after an optional gap and records its pattern once it is taken.
	task automatic offer_word(logic [FW-1:0] s_m1, logic [FW-1:0] p_m1, logic [FW-1:0] rot,
			logic [PW-1:0] pattern, int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid       <= 1'b1;
		steps_minus_one  <= s_m1;
		pulses_minus_one <= p_m1;
		rotation         <= rot;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
		expected_patterns.push_back(pattern);
		words_sent++;
	endtask

	// Sender: reset, directed table, random words, then drain and report.
	initial begin
		logic [FW-1:0] s_m1;
		logic [FW-1:0] p_m1;
		logic [FW-1:0] rot;
		logic [PW-1:0] pattern;
		int            n;
		arst_n           <= 1'b0;
		item_valid       <= 1'b0;
		steps_minus_one  <= '0;
		pulses_minus_one <= '0;
		rotation         <= '0;
		words_sent       = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_COUNT; n++) begin
			if (directed_cases[n].typed) begin
				pattern = directed_cases[n].pattern;
			end else begin
				pattern = euclid_pattern(directed_cases[n].steps_m1,
					directed_cases[n].pulses_m1, directed_cases[n].rot);
			end
			offer_word(directed_cases[n].steps_m1, directed_cases[n].pulses_m1,
				directed_cases[n].rot, pattern, (n % 3 == 0) ? idle_cycles() : 0);
		end

		// Random words, mostly with pulses within the step count; some bursts without gaps.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			s_m1 = FW'($urandom_range(0, 15));
			if ($urandom_range(0, 3) != 0) begin
				p_m1 = FW'($urandom_range(0, s_m1));
			end else begin
				p_m1 = FW'($urandom_range(0, 15));
			end
			rot = FW'($urandom_range(0, 15));
			offer_word(s_m1, p_m1, rot, euclid_pattern(s_m1, p_m1, rot),
				(n % 80 < 20) ? 0 : idle_cycles());
		end
		item_valid <= 1'b0;

		while (expected_patterns.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words (%0d from the directed table), checked %0d patterns.",
			words_sent, DIRECTED_COUNT, patterns_checked);
		$display("Receiver stalls included one hold of %0d cycles against a busy sender.",
			LONG_HOLD);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Receiver: random stalls, stretches without any, and one long hold-off.
	initial begin
		int stall_left;
		result_ready   <= 1'b0;
		long_hold_done = 1'b0;
		stall_left     = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (!long_hold_done && patterns_checked >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD - 1;
				result_ready   <= 1'b0;
			end else if ((cycle_count / 512) % 4 == 0) begin
				result_ready <= 1'b1;
			end else begin
				stall_left = idle_cycles();
				if (stall_left > 0) begin
					stall_left--;
				end
				result_ready <= (stall_left == 0) && ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Result words are compared with the oldest pending pattern at the falling edge before they go.
	initial begin
		patterns_checked = 0;
		mismatches       = 0;
	end
	always @(negedge clk) begin
		logic [PW-1:0] want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_patterns.size() == 0) begin
				$error("step_pattern %h arrived with no word pending", step_pattern);
				mismatches++;
			end else begin
				want = expected_patterns.pop_front();
				patterns_checked++;
				if (step_pattern !== want) begin
					$error("step_pattern mismatch: expected %h, got %h", want, step_pattern);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d patterns pending.", cycle_count,
			expected_patterns.size());
		$display("simulation failed");
		$finish;
	end

endmodule
